// ===== rtl/core/triangle_membership_integral_core_macros.svh =====
// assertion macros for the triangle membership integral core
`ifndef TRIANGLE_MEMBERSHIP_INTEGRAL_CORE_MACROS_SVH
`define TRIANGLE_MEMBERSHIP_INTEGRAL_CORE_MACROS_SVH

// condition implies consequence in the same cycle
`define TMI_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define TMI_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// ===== rtl/core/tmi_pkg.sv =====
// shared constants and types for the triangle membership integral core
package tmi_pkg;
  localparam int FRAC_BITS = 16;
  localparam int IN_W = 20;
  localparam int OUT_W = 18;
  localparam int U_W = (IN_W > FRAC_BITS + 2 ? IN_W : FRAC_BITS + 2) + 2;
  localparam int W_W = IN_W;
  localparam int SQ_W = 2 * W_W;
  localparam int NUM_W = 2 * W_W + 1;
  localparam int D_W = W_W + 1;
  localparam int QW = FRAC_BITS + 1;
  localparam int REM_W = NUM_W + QW;
  localparam int N_STAGES = 4 + QW + 1;
  localparam logic signed [U_W-1:0] ONE = U_W'(1) <<< FRAC_BITS;
  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  typedef struct packed {
    logic neg;
    logic degen;
  } side_t;
endpackage

// ===== rtl/core/triangle_membership_integral_core.sv =====
// top level of the triangle membership integral core
// Usage: one request carries lower_bound, upper_bound, centre and half_width
// (signed Q4.16). It is taken at a clock edge with in_valid high and
// in_stall low. One result (area, signed Q2.16, and degenerate) leaves per
// request, in order, at an edge with out_valid high and out_stall low.
// The request passes 22 register stages, the first loaded at the accepting
// edge: two prep stages, a square stage, a numerator stage, 17 divider
// stages (one quotient bit each) and the output register.
// Throughput is one request per cycle while out_stall stays low; every stage,
// the divider included, can take a new request each cycle.
// Each stage holds its own valid bit and loads whenever it is empty or the
// stage after it moves, so bubbles close up while the receiver stalls.
// in_stall rises only when every stage holds a request and out_stall is
// high. Reset empties the pipeline; no request is in flight afterwards.
`include "triangle_membership_integral_core_macros.svh"
module triangle_membership_integral_core (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [tmi_pkg::IN_W-1:0] lower_bound,
  input  logic signed [tmi_pkg::IN_W-1:0] upper_bound,
  input  logic signed [tmi_pkg::IN_W-1:0] centre,
  input  logic signed [tmi_pkg::IN_W-1:0] half_width,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [tmi_pkg::OUT_W-1:0] area,
  output logic degenerate
);
  localparam int N = tmi_pkg::N_STAGES;

  logic [N-1:0] vld;
  logic [N:0] en;

  always_comb begin
    en[N] = !out_stall;
    for (int i = N - 1; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign in_stall = !en[0];
  assign out_valid = vld[N-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < N; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  logic [tmi_pkg::W_W-1:0] t_hi, t_lo, w_p;
  logic pos_hi, pos_lo;
  tmi_pkg::side_t side_p, side_m, side_d;
  logic [tmi_pkg::NUM_W-1:0] num;
  logic [tmi_pkg::D_W-1:0] dvs;
  logic [tmi_pkg::QW-1:0] quo;

  tmi_prep u_prep (
    .clk(clk), .en(en[1:0]),
    .lower_bound(lower_bound), .upper_bound(upper_bound),
    .centre(centre), .half_width(half_width),
    .t_hi(t_hi), .t_lo(t_lo), .pos_hi(pos_hi), .pos_lo(pos_lo),
    .w_out(w_p), .side_out(side_p)
  );

  tmi_mult u_mult (
    .clk(clk), .en(en[3:2]),
    .t_hi(t_hi), .t_lo(t_lo), .pos_hi(pos_hi), .pos_lo(pos_lo),
    .w_in(w_p), .side_in(side_p),
    .num(num), .dvs(dvs), .side_out(side_m)
  );

  tmi_div u_div (
    .clk(clk), .en(en[4+tmi_pkg::QW-1:4]),
    .num(num), .dvs(dvs), .side_in(side_m),
    .quo(quo), .side_out(side_d)
  );

  logic signed [tmi_pkg::QW+1:0] sv;
  logic signed [tmi_pkg::OUT_W-1:0] area_next;

  always_comb begin
    sv = $signed({2'b00, quo});
    if (side_d.neg) begin
      sv = -sv;
    end
    if (side_d.degen) begin
      area_next = '0;
    end else if (sv > (tmi_pkg::QW+2)'(tmi_pkg::OUT_MAX)) begin
      area_next = tmi_pkg::OUT_MAX;
    end else if (sv < (tmi_pkg::QW+2)'(tmi_pkg::OUT_MIN)) begin
      area_next = tmi_pkg::OUT_MIN;
    end else begin
      area_next = tmi_pkg::OUT_W'(sv);
    end
  end

  always_ff @(posedge clk) begin
    if (en[N-1]) begin
      area <= area_next;
      degenerate <= side_d.degen;
    end
  end

  `TMI_ASSERT_NOW(a_degen_zero, out_valid && degenerate, area == '0, "degenerate with area")
  `TMI_ASSERT_NOW(a_stall_full, in_stall, (&vld) && out_stall, "input stalled with room")
  `TMI_ASSERT_NOW(a_area_range, out_valid,
    (area <= tmi_pkg::OUT_W'(tmi_pkg::ONE)) && (area >= -tmi_pkg::OUT_W'(tmi_pkg::ONE)),
    "area beyond one")
  `TMI_ASSERT_NEXT(a_accept_moves, in_valid && !in_stall, vld[0], "request lost at entry")
endmodule

// ===== rtl/core/tmi_prep.sv =====
// input clipping, swap and offset clamp stages
module tmi_prep (
  input  logic clk,
  input  logic [1:0] en,
  input  logic signed [tmi_pkg::IN_W-1:0] lower_bound,
  input  logic signed [tmi_pkg::IN_W-1:0] upper_bound,
  input  logic signed [tmi_pkg::IN_W-1:0] centre,
  input  logic signed [tmi_pkg::IN_W-1:0] half_width,
  output logic [tmi_pkg::W_W-1:0] t_hi,
  output logic [tmi_pkg::W_W-1:0] t_lo,
  output logic pos_hi,
  output logic pos_lo,
  output logic [tmi_pkg::W_W-1:0] w_out,
  output tmi_pkg::side_t side_out
);
  logic signed [tmi_pkg::U_W-1:0] lo_c, hi_c, c_r;
  logic [tmi_pkg::W_W-1:0] w_r;
  tmi_pkg::side_t side_r;

  logic signed [tmi_pkg::U_W-1:0] lo_e, hi_e, a, b, a_c, b_c, w_e;
  logic [tmi_pkg::W_W-1:0] w_abs;
  logic neg;

  always_comb begin
    lo_e = tmi_pkg::U_W'(lower_bound);
    hi_e = tmi_pkg::U_W'(upper_bound);
    neg = lo_e > hi_e;
    a = neg ? hi_e : lo_e;
    b = neg ? lo_e : hi_e;
    a_c = (a < 0) ? '0 : a;
    b_c = (b > tmi_pkg::ONE) ? tmi_pkg::ONE : b;
    w_e = tmi_pkg::U_W'(half_width);
    w_abs = (w_e < 0) ? tmi_pkg::W_W'(-w_e) : tmi_pkg::W_W'(w_e);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      lo_c <= a_c;
      hi_c <= b_c;
      c_r <= tmi_pkg::U_W'(centre);
      w_r <= w_abs;
      side_r.neg <= neg;
      side_r.degen <= (w_abs == '0) || (a_c >= b_c);
    end
  end

  logic signed [tmi_pkg::U_W-1:0] ws, uh, ul, uh_c, ul_c, th_s, tl_s;

  always_comb begin
    ws = $signed({{(tmi_pkg::U_W-tmi_pkg::W_W){1'b0}}, w_r});
    uh = hi_c - c_r;
    ul = lo_c - c_r;
    uh_c = (uh < -ws) ? -ws : ((uh > ws) ? ws : uh);
    ul_c = (ul < -ws) ? -ws : ((ul > ws) ? ws : ul);
    th_s = (uh_c < 0) ? uh_c + ws : ws - uh_c;
    tl_s = (ul_c < 0) ? ul_c + ws : ws - ul_c;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      t_hi <= th_s[tmi_pkg::W_W-1:0];
      t_lo <= tl_s[tmi_pkg::W_W-1:0];
      pos_hi <= uh_c >= 0;
      pos_lo <= ul_c >= 0;
      w_out <= w_r;
      side_out <= side_r;
    end
  end
endmodule

// ===== rtl/core/tmi_mult.sv =====
// square and numerator stages
module tmi_mult (
  input  logic clk,
  input  logic [1:0] en,
  input  logic [tmi_pkg::W_W-1:0] t_hi,
  input  logic [tmi_pkg::W_W-1:0] t_lo,
  input  logic pos_hi,
  input  logic pos_lo,
  input  logic [tmi_pkg::W_W-1:0] w_in,
  input  tmi_pkg::side_t side_in,
  output logic [tmi_pkg::NUM_W-1:0] num,
  output logic [tmi_pkg::D_W-1:0] dvs,
  output tmi_pkg::side_t side_out
);
  logic [tmi_pkg::SQ_W-1:0] sq_h, sq_l, ww;
  logic ph, pl;
  logic [tmi_pkg::W_W-1:0] w_r;
  tmi_pkg::side_t side_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sq_h <= t_hi * t_hi;
      sq_l <= t_lo * t_lo;
      ww <= w_in * w_in;
      ph <= pos_hi;
      pl <= pos_lo;
      w_r <= w_in;
      side_r <= side_in;
    end
  end

  logic [tmi_pkg::NUM_W-1:0] ww2, cum_h, cum_l;

  always_comb begin
    ww2 = {ww, 1'b0};
    cum_h = ph ? ww2 - tmi_pkg::NUM_W'(sq_h) : tmi_pkg::NUM_W'(sq_h);
    cum_l = pl ? ww2 - tmi_pkg::NUM_W'(sq_l) : tmi_pkg::NUM_W'(sq_l);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      num <= cum_h - cum_l;
      dvs <= {w_r, 1'b0};
      side_out <= side_r;
    end
  end
endmodule

// ===== rtl/core/tmi_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module tmi_div (
  input  logic clk,
  input  logic [tmi_pkg::QW-1:0] en,
  input  logic [tmi_pkg::NUM_W-1:0] num,
  input  logic [tmi_pkg::D_W-1:0] dvs,
  input  tmi_pkg::side_t side_in,
  output logic [tmi_pkg::QW-1:0] quo,
  output tmi_pkg::side_t side_out
);
  logic [tmi_pkg::REM_W-1:0] rem [tmi_pkg::QW+1];
  logic [tmi_pkg::QW-1:0] q [tmi_pkg::QW+1];
  logic [tmi_pkg::D_W-1:0] d [tmi_pkg::QW+1];
  tmi_pkg::side_t sd [tmi_pkg::QW+1];

  assign rem[0] = tmi_pkg::REM_W'(num);
  assign q[0] = '0;
  assign d[0] = dvs;
  assign sd[0] = side_in;

  for (genvar k = 0; k < tmi_pkg::QW; k++) begin : g_stage
    localparam int B = tmi_pkg::QW - 1 - k;
    logic [tmi_pkg::REM_W-1:0] trial;
    logic take;
    assign trial = tmi_pkg::REM_W'(d[k]) << B;
    assign take = rem[k] >= trial;
    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem[k+1] <= take ? rem[k] - trial : rem[k];
        q[k+1] <= q[k] | (tmi_pkg::QW'(take) << B);
        d[k+1] <= d[k];
        sd[k+1] <= sd[k];
      end
    end
  end

  assign quo = q[tmi_pkg::QW];
  assign side_out = sd[tmi_pkg::QW];
endmodule

// ===== verif/tb_triangle_membership_integral_core.sv =====
// testbench for the triangle membership integral core: directed table plus random requests
`timescale 1ns / 1ps
module tb_triangle_membership_integral_core;

  typedef struct {
    logic signed [tmi_pkg::IN_W-1:0] lo;
    logic signed [tmi_pkg::IN_W-1:0] hi;
    logic signed [tmi_pkg::IN_W-1:0] c;
    logic signed [tmi_pkg::IN_W-1:0] w;
    bit known;
    logic signed [tmi_pkg::OUT_W-1:0] k_area;
    logic k_degen;
  } row_t;

  typedef struct {
    logic signed [tmi_pkg::OUT_W-1:0] area;
    logic degen;
  } res_t;

  localparam int N_RANDOM = 1100;
  localparam longint CYCLE_LIMIT = 200000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic signed [tmi_pkg::IN_W-1:0] lower_bound;
  logic signed [tmi_pkg::IN_W-1:0] upper_bound;
  logic signed [tmi_pkg::IN_W-1:0] centre;
  logic signed [tmi_pkg::IN_W-1:0] half_width;
  logic out_valid;
  logic out_stall;
  logic signed [tmi_pkg::OUT_W-1:0] area;
  logic degenerate;

  res_t pending_areas[$];
  row_t table_rows[$];
  int mismatches;
  int n_checked;
  int n_degen;
  longint cycles;

  triangle_membership_integral_core u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .lower_bound(lower_bound), .upper_bound(upper_bound), .centre(centre),
    .half_width(half_width), .out_valid(out_valid), .out_stall(out_stall),
    .area(area), .degenerate(degenerate)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // 2*w times the membership integral from -inf to offset u
  function automatic longint ramp_area2(longint u, longint w);
    if (u < -w) u = -w;
    if (u > w) u = w;
    if (u < 0) return (u + w) * (u + w);
    return 2 * w * w - (w - u) * (w - u);
  endfunction

  function automatic res_t triangle_area(row_t r);
    longint lo, hi, c, w, one, num, a, t;
    bit neg;
    res_t res;
    lo = r.lo; hi = r.hi; c = r.c; w = r.w;
    one = longint'(1) << tmi_pkg::FRAC_BITS;
    neg = 0;
    a = 0;
    res.degen = 0;
    if (lo > hi) begin
      t = lo; lo = hi; hi = t; neg = 1;
    end
    if (lo < 0) lo = 0;
    if (hi > one) hi = one;
    if (w < 0) w = -w;
    if (w == 0 || lo >= hi) begin
      res.degen = 1;
    end else begin
      num = ramp_area2(hi - c, w) - ramp_area2(lo - c, w);
      a = num / (2 * w);
      if (neg) a = -a;
    end
    if (a > 131071) a = 131071;
    if (a < -131072) a = -131072;
    res.area = a[tmi_pkg::OUT_W-1:0];
    return res;
  endfunction

  function automatic row_t mk(int lo, int hi, int c, int w, bit known = 0,
                              int ka = 0, bit kd = 0);
    row_t r;
    r.lo = tmi_pkg::IN_W'(lo); r.hi = tmi_pkg::IN_W'(hi);
    r.c = tmi_pkg::IN_W'(c); r.w = tmi_pkg::IN_W'(w);
    r.known = known; r.k_area = tmi_pkg::OUT_W'(ka); r.k_degen = kd;
    return r;
  endfunction

  function automatic int rnd_field();
    int x;
    case ($urandom_range(0, 5))
      0: x = $urandom_range(0, 65536);
      1: x = $urandom_range(0, 65536) - 32768;
      2: x = $urandom_range(0, 98304) - 16384;
      3: x = -524288 + $urandom_range(0, 3);
      4: x = 524287 - $urandom_range(0, 3);
      default: x = int'($urandom_range(0, 1048575)) - 524288;
    endcase
    return x;
  endfunction

  task automatic send_request(row_t r);
    res_t e;
    int gap;
    gap = $urandom_range(0, 10) * $urandom_range(0, 1);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    lower_bound <= r.lo;
    upper_bound <= r.hi;
    centre <= r.c;
    half_width <= r.w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    e = triangle_area(r);
    if (r.known) begin
      e.area = r.k_area;
      e.degen = r.k_degen;
    end
    pending_areas.push_back(e);
    @(negedge clk);
  endtask

  // receiver: random stall per result, some stretches with none
  initial begin
    int gap;
    out_stall = 1'b1;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    res_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_areas.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result area=%0d", area);
      end else begin
        e = pending_areas.pop_front();
        n_checked++;
        if (e.degen) n_degen++;
        if (area !== e.area || degenerate !== e.degen) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: area exp %0d got %0d, degenerate exp %0b got %0b",
                     e.area, area, e.degen, degenerate);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    row_t r;
    int settle;
    mismatches = 0; n_checked = 0; n_degen = 0; cycles = 0;
    rst = 1'b1; in_valid = 1'b0;
    lower_bound = '0; upper_bound = '0; centre = '0; half_width = '0;
    // zero width
    table_rows.push_back(mk(0, 65536, 32768, 0, 1, 0, 1));
    // empty after clipping
    table_rows.push_back(mk(-524288, -1, 0, 65536, 1, 0, 1));
    table_rows.push_back(mk(65536, 524287, 0, 65536, 1, 0, 1));
    table_rows.push_back(mk(100, 100, 100, 100, 1, 0, 1));
    // interval outside the triangle
    table_rows.push_back(mk(0, 65536, -300000, 1000, 1, 0, 0));
    table_rows.push_back(mk(0, 65536, 400000, 1000, 1, 0, 0));
    // full triangle inside: area equals w
    table_rows.push_back(mk(0, 65536, 32768, 16384, 1, 16384, 0));
    table_rows.push_back(mk(65536, 0, 32768, 16384, 1, -16384, 0));
    table_rows.push_back(mk(0, 65536, 32768, -16384, 1, 16384, 0));
    // extremes
    table_rows.push_back(mk(-524288, 524287, 0, 524287));
    table_rows.push_back(mk(524287, -524288, 524287, -524288));
    table_rows.push_back(mk(-524288, 524287, -524288, -524288));
    table_rows.push_back(mk(0, 65536, 32768, 524287));
    table_rows.push_back(mk(0, 65536, 32768, 1));
    table_rows.push_back(mk(0, 65536, 32768, -1));
    table_rows.push_back(mk(1, 65535, 0, 3));
    // odd divisions, reversed truncation
    table_rows.push_back(mk(7, 12345, 1000, 777));
    table_rows.push_back(mk(12345, 7, 1000, 777));
    table_rows.push_back(mk(40000, 20000, 30001, -9999));
    table_rows.push_back(mk(-1, 65537, 65536, 65536));
    table_rows.push_back(mk(524287, 524287, 524287, 524287));
    table_rows.push_back(mk(-349526, 349525, 174762, -174763));
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (table_rows[i]) send_request(table_rows[i]);
    for (int i = 0; i < N_RANDOM; i++) begin
      r = mk(rnd_field(), rnd_field(), rnd_field(), rnd_field());
      if ($urandom_range(0, 3) == 0)
        r.w = tmi_pkg::IN_W'(int'($urandom_range(0, 15)) - 8);
      send_request(r);
    end
    in_valid <= 1'b0;
    while (pending_areas.size() != 0) @(posedge clk);
    settle = 0;
    while (settle < 40) begin
      @(posedge clk);
      settle++;
    end
    $display("checked %0d results (%0d degenerate) from %0d directed and %0d random requests",
             n_checked, n_degen, table_rows.size(), N_RANDOM);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/tmi_pkg.sv
rtl/core/tmi_prep.sv
rtl/core/tmi_mult.sv
rtl/core/tmi_div.sv
rtl/core/triangle_membership_integral_core.sv
verif/tb_triangle_membership_integral_core.sv
